[rtl/core/tms_pkg.sv]
// Shared types and constants for the translation match search core.
// No dependencies.
package tms_pkg;

  localparam int STR_BITS = 192;

  typedef enum logic [1:0] {
    MODE_WRITE_SLOT = 2'd0,
    MODE_SET_COUNT  = 2'd1,
    MODE_SET_TOTAL  = 2'd2,
    MODE_QUERY      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ENTRY,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  // C-string compare of two 24-byte strings, bytes in low-first order
  function automatic logic str_equal(input logic [STR_BITS-1:0] a,
                                     input logic [STR_BITS-1:0] b);
    logic eq;
    logic stop;
    eq = 1'b1;
    stop = 1'b0;
    for (int i = 0; i < STR_BITS / 8; i++) begin
      if (!stop) begin
        if (a[i*8 +: 8] != b[i*8 +: 8]) begin
          eq = 1'b0;
          stop = 1'b1;
        end else if (a[i*8 +: 8] == 8'd0) begin
          stop = 1'b1;
        end
      end
    end
    return eq;
  endfunction

endpackage

[rtl/core/tms_slot_mem.sv]
// Slot string memory: one row per slot holding the language and word strings.
// Depends on tms_pkg.
module tms_slot_mem
  import tms_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [STR_BITS-1:0] wr_lang,
  input  logic [STR_BITS-1:0] wr_word,
  input  logic [AW-1:0]       rd_addr,
  output logic [STR_BITS-1:0] rd_lang,
  output logic [STR_BITS-1:0] rd_word
);

  logic [2*STR_BITS-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_lang, wr_word};
    end
    {rd_lang, rd_word} <= mem[rd_addr];
  end

endmodule

[rtl/core/translation_match_search_core.sv]
// Translation match search: a table of entries, each with up to MAX_SLOTS
// language/word slots. After reset busy stays high while the slot count table
// is cleared. Writes, count and total updates strobe in the cycle after the
// accepting edge; a new beat is taken only after that strobe. A query visits
// each entry in use: an ENTRY state fetches its slot count, then per slot a
// READ state issues the memory read and a CMP state compares, stopping at the
// first match; an entry with no match also passes READ once more to see its
// slots are done. The slot memory's single read port means slots are read one
// at a time. busy stays high through the strobe; the receiver cannot stall, so
// the result is shown for exactly one cycle.
// Depends on tms_pkg and tms_slot_mem.
module translation_match_search_core
  import tms_pkg::*;
#(
  parameter int MAX_ENTRIES = 128,
  parameter int MAX_SLOTS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [6:0]  entry_index,
  input  logic [2:0]  slot_index,
  input  logic [7:0]  amount,
  input  logic [7:0]  nth_match,
  input  logic [63:0] lang_chunk_0,
  input  logic [63:0] lang_chunk_1,
  input  logic [63:0] lang_chunk_2,
  input  logic [63:0] word_chunk_0,
  input  logic [63:0] word_chunk_1,
  input  logic [63:0] word_chunk_2,
  output logic        strobe,
  output logic        status,
  output logic [7:0]  match_count,
  output logic        found,
  output logic [6:0]  found_index
);

  localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int TW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = EW + SW;

  state_t state, state_next;

  logic [CW-1:0]       slot_counts [MAX_ENTRIES];
  logic [TW-1:0]       entry_total;
  logic [1:0]          op;
  logic [7:0]          nth;
  logic [STR_BITS-1:0] q_lang, q_word;
  logic [TW-1:0]       ent;
  logic [SW:0]         slot;
  logic [CW-1:0]       cur_cnt;
  logic [7:0]          cnt;
  logic                hit;
  logic [6:0]          hit_idx;
  logic                rej;
  logic [EW-1:0]       clr_idx;

  logic [STR_BITS-1:0] rd_lang, rd_word;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic                wr_en;
  logic                slot_ok, in_range_e;
  logic                count_ok;
  logic                cnt_we;
  logic [EW-1:0]       cnt_waddr;
  logic [CW-1:0]       cnt_wdata;
  logic                match;
  logic                accept;

  assign accept = start && !busy;
  assign in_range_e = {1'b0, entry_index} < 8'(MAX_ENTRIES);
  assign slot_ok = in_range_e && ({1'b0, slot_index} < 4'(MAX_SLOTS));
  assign count_ok = in_range_e && (amount <= 8'(MAX_SLOTS));
  assign wr_en = accept && (mode_t'(mode) == MODE_WRITE_SLOT) && slot_ok;
  assign wr_addr = AW'({entry_index, {SW{1'b0}}}) | AW'(slot_index);
  assign rd_addr = AW'((AW'(ent) << SW) | AW'(slot[SW-1:0]));

  // slot count table port: clearing pass after reset, else count writes
  assign cnt_we = (state == ST_CLEAR) ||
                  (accept && (mode_t'(mode) == MODE_SET_COUNT) && count_ok);
  assign cnt_waddr = (state == ST_CLEAR) ? clr_idx : EW'(entry_index);
  assign cnt_wdata = (state == ST_CLEAR) ? '0 : CW'(amount);

  tms_slot_mem #(.DEPTH(MAX_ENTRIES * MAX_SLOTS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_lang ({lang_chunk_2, lang_chunk_1, lang_chunk_0}),
    .wr_word ({word_chunk_2, word_chunk_1, word_chunk_0}),
    .rd_addr (rd_addr),
    .rd_lang (rd_lang),
    .rd_word (rd_word)
  );

  // slot compare against the query strings
  assign match = str_equal(rd_word, q_word) &&
                 ((q_lang[7:0] == 8'd0) || str_equal(rd_lang, q_lang));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == EW'(MAX_ENTRIES - 1)) begin
        state_next = ST_IDLE;
      end
      ST_IDLE: if (accept) begin
        state_next = (mode_t'(mode) == MODE_QUERY) ? ST_ENTRY : ST_DONE;
      end
      ST_ENTRY: state_next = (ent < entry_total) ? ST_READ : ST_DONE;
      ST_READ: state_next = (slot < (SW+1)'(cur_cnt)) ? ST_CMP : ST_ENTRY;
      ST_CMP: state_next = match ? ST_ENTRY : ST_READ;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != ST_IDLE);
    strobe = (state == ST_DONE);
    status = rej;
    match_count = cnt;
    found = hit;
    found_index = hit_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      entry_total <= '0;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (accept && mode_t'(mode) == MODE_SET_TOTAL && amount <= 8'(MAX_ENTRIES)) begin
        entry_total <= TW'(amount);
      end
    end
  end

  // slot count table: one write per cycle
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      slot_counts[cnt_waddr] <= cnt_wdata;
    end
  end

  // command capture and query walk: entry counter, slot counter, match tally
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (accept) begin
        op <= mode;
        nth <= nth_match;
        q_lang <= {lang_chunk_2, lang_chunk_1, lang_chunk_0};
        q_word <= {word_chunk_2, word_chunk_1, word_chunk_0};
        ent <= '0;
        cnt <= '0;
        hit <= 1'b0;
        hit_idx <= '0;
        case (mode_t'(mode))
          MODE_WRITE_SLOT: rej <= !slot_ok;
          MODE_SET_COUNT:  rej <= !count_ok;
          MODE_SET_TOTAL:  rej <= amount > 8'(MAX_ENTRIES);
          default:         rej <= 1'b0;
        endcase
      end
      ST_ENTRY: begin
        slot <= '0;
        cur_cnt <= slot_counts[ent[EW-1:0]];
      end
      ST_READ: if (!(slot < (SW+1)'(cur_cnt))) ent <= ent + 1'b1;
      ST_CMP: begin
        slot <= slot + 1'b1;
        if (match) begin
          cnt <= cnt + 1'b1;
          if (nth != 8'd0 && (cnt + 1'b1) == nth) begin
            hit <= 1'b1;
            hit_idx <= 7'(ent);
          end
          ent <= ent + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // a strobe always follows in the cycle after a non-query beat
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (accept && mode_t'(mode) != MODE_QUERY) |=> strobe) else $error("write beat did not finish");
  // found only on queries
  a_found_query: assert property (@(posedge clk) disable iff (rst)
    (strobe && found) |-> (mode_t'(op) == MODE_QUERY && nth != 8'd0)) else $error("bad found");
  // never report more matches than entries in use
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ({1'b0, match_count} <= 9'(entry_total))) else $error("count overflow");
  // busy covers the strobe cycle
  a_busy_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe while idle");

endmodule

[tb/tb_top.sv]
// Testbench for translation_match_search_core: directed and random commands
// checked against an in-bench table model. Depends on tms_pkg and the core RTL.
module tb_top;
  import tms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 128;
  localparam int NUM_SLOTS   = 8;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    mode_t        mode;
    logic [6:0]   entry;
    logic [2:0]   slot;
    logic [7:0]   amount;
    logic [7:0]   nth;
    logic [191:0] lang;
    logic [191:0] word;
  } cmd_t;

  typedef struct {
    logic       status;
    logic [7:0] count;
    logic       found;
    logic [6:0] index;
  } reply_t;

  logic clk, rst, start, busy, strobe;
  logic [1:0]  mode;
  logic [6:0]  entry_index;
  logic [2:0]  slot_index;
  logic [7:0]  amount, nth_match;
  logic [63:0] lang_chunk_0, lang_chunk_1, lang_chunk_2;
  logic [63:0] word_chunk_0, word_chunk_1, word_chunk_2;
  logic        status, found;
  logic [7:0]  match_count;
  logic [6:0]  found_index;

  translation_match_search_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .entry_index(entry_index), .slot_index(slot_index), .amount(amount),
    .nth_match(nth_match),
    .lang_chunk_0(lang_chunk_0), .lang_chunk_1(lang_chunk_1),
    .lang_chunk_2(lang_chunk_2),
    .word_chunk_0(word_chunk_0), .word_chunk_1(word_chunk_1),
    .word_chunk_2(word_chunk_2),
    .strobe(strobe), .status(status), .match_count(match_count),
    .found(found), .found_index(found_index)
  );

  // table mirror
  logic [191:0] lang_tab [NUM_ENTRIES][NUM_SLOTS];
  logic [191:0] word_tab [NUM_ENTRIES][NUM_SLOTS];
  int unsigned  slots_used [NUM_ENTRIES];
  int unsigned  written_prefix [NUM_ENTRIES];
  bit           slot_written [NUM_ENTRIES][NUM_SLOTS];
  int unsigned  entries_used;

  reply_t       pending_replies [$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  bit           gaps_on;
  logic [191:0] words [8];
  logic [191:0] langs [3];

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // byte-wise compare up to the first zero byte
  function automatic bit same_text(logic [191:0] a, logic [191:0] b);
    for (int i = 0; i < 24; i++) begin
      if (a[i*8 +: 8] != b[i*8 +: 8]) return 1'b0;
      if (a[i*8 +: 8] == 8'd0) return 1'b1;
    end
    return 1'b1;
  endfunction

  // apply one beat to the mirror and return the reply it should produce
  function automatic reply_t table_step(cmd_t c);
    reply_t r;
    bit hit;
    r = '{default: '0};
    case (c.mode)
      MODE_WRITE_SLOT: begin
        lang_tab[c.entry][c.slot] = c.lang;
        word_tab[c.entry][c.slot] = c.word;
        slot_written[c.entry][c.slot] = 1'b1;
        while (written_prefix[c.entry] < NUM_SLOTS &&
               slot_written[c.entry][written_prefix[c.entry]])
          written_prefix[c.entry]++;
      end
      MODE_SET_COUNT: begin
        if (c.amount > NUM_SLOTS) r.status = 1'b1;
        else slots_used[c.entry] = 32'(c.amount);
      end
      MODE_SET_TOTAL: begin
        if (c.amount > NUM_ENTRIES) r.status = 1'b1;
        else entries_used = 32'(c.amount);
      end
      default: begin
        for (int e = 0; e < entries_used; e++) begin
          hit = 1'b0;
          for (int s = 0; s < slots_used[e]; s++)
            if (same_text(word_tab[e][s], c.word) &&
                (c.lang[7:0] == 8'd0 || same_text(lang_tab[e][s], c.lang)))
              hit = 1'b1;
          if (hit) begin
            r.count++;
            if (c.nth != 0 && r.count == c.nth) begin
              r.found = 1'b1;
              r.index = 7'(e);
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [191:0] noise();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // random text of 1..10 or 24 nonzero bytes, zero padded
  function automatic logic [191:0] make_text();
    logic [191:0] t;
    int unsigned len;
    t = '0;
    len = ($urandom_range(0, 5) == 0) ? 24 : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) t[i*8 +: 8] = 8'($urandom_range(1, 255));
    return t;
  endfunction

  // one beat: hold start until accepted, then record the expected reply
  task automatic send_cmd(cmd_t c);
    mode <= c.mode;
    entry_index <= c.entry;
    slot_index <= c.slot;
    amount <= c.amount;
    nth_match <= c.nth;
    {lang_chunk_2, lang_chunk_1, lang_chunk_0} <= c.lang;
    {word_chunk_2, word_chunk_1, word_chunk_0} <= c.word;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_replies.push_back(table_step(c));
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic cmd_t blank_cmd(mode_t m);
    cmd_t c;
    c.mode = m;
    c.entry = 7'($urandom);
    c.slot = 3'($urandom);
    c.amount = 8'($urandom);
    c.nth = 8'($urandom);
    c.lang = noise();
    c.word = noise();
    return c;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // fixed corner cases: rejects, empty table, wildcard language, nth limits
  task automatic test_directed();
    cmd_t c;
    logic [191:0] w, l;
    w = words[0];
    l = langs[0];
    c = blank_cmd(MODE_QUERY); c.nth = 1; send_cmd(c);
    c = blank_cmd(MODE_WRITE_SLOT); c.entry = 0; c.slot = 0; c.lang = l; c.word = w;
    send_cmd(c);
    c = blank_cmd(MODE_WRITE_SLOT); c.entry = 127; c.slot = 7;
    c.lang = '1; c.word = '1; send_cmd(c);
    c = blank_cmd(MODE_SET_COUNT); c.entry = 0; c.amount = 1; send_cmd(c);
    c = blank_cmd(MODE_SET_COUNT); c.entry = 5; c.amount = 9; send_cmd(c);
    c = blank_cmd(MODE_SET_COUNT); c.entry = 127; c.amount = 255; send_cmd(c);
    c = blank_cmd(MODE_SET_TOTAL); c.amount = 129; send_cmd(c);
    c = blank_cmd(MODE_SET_TOTAL); c.amount = 255; send_cmd(c);
    c = blank_cmd(MODE_SET_TOTAL); c.amount = 1; send_cmd(c);
    c = blank_cmd(MODE_QUERY); c.lang = l; c.word = w; c.nth = 1; send_cmd(c);
    c.lang = noise(); c.lang[7:0] = 8'd0; c.nth = 0; send_cmd(c);
    c.nth = 2; send_cmd(c);
    c.nth = 255; send_cmd(c);
    // bytes after the terminator must not matter
    c.lang = l | ({192{1'b1}} << 184); c.word = w; c.nth = 1; send_cmd(c);
    c = blank_cmd(MODE_SET_TOTAL); c.amount = 128; send_cmd(c);
    c = blank_cmd(MODE_QUERY); c.lang = l; c.word = w; c.nth = 1; send_cmd(c);
    c.word = noise(); c.nth = 0; send_cmd(c);
    c = blank_cmd(MODE_SET_TOTAL); c.amount = 0; send_cmd(c);
  endtask

  // random mix, weighted toward building entries and querying them
  task automatic test_random(int unsigned beats);
    cmd_t c;
    int unsigned pick, e, lim;
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 99);
      e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
      if (pick < 35) begin
        c = blank_cmd(MODE_WRITE_SLOT);
        c.entry = 7'(e);
        if (written_prefix[e] < NUM_SLOTS && $urandom_range(0, 9) != 0)
          c.slot = 3'(written_prefix[e]);
        c.word = ($urandom_range(0, 9) == 0) ? make_text() : words[$urandom_range(0, 7)];
        c.lang = ($urandom_range(0, 9) == 0) ? make_text() : langs[$urandom_range(0, 2)];
        if ($urandom_range(0, 7) == 0) c.word = noise();
      end else if (pick < 50) begin
        c = blank_cmd(MODE_SET_COUNT);
        c.entry = 7'(e);
        lim = written_prefix[e];
        c.amount = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 255)
                                                  : $urandom_range(0, lim));
      end else if (pick < 60) begin
        c = blank_cmd(MODE_SET_TOTAL);
        lim = $urandom_range(0, 19);
        c.amount = 8'((lim == 0) ? 128 : (lim == 1) ? $urandom_range(129, 255)
                      : $urandom_range(0, 16));
      end else begin
        c = blank_cmd(MODE_QUERY);
        if ($urandom_range(0, 4) != 0) c.word = words[$urandom_range(0, 7)];
        lim = $urandom_range(0, 9);
        if (lim < 3) c.lang[7:0] = 8'd0;
        else if (lim < 8) c.lang = langs[$urandom_range(0, 2)];
        c.nth = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 5));
      end
      send_cmd(c);
    end
  endtask

  // sender holds off until every reply has come back
  task automatic test_drain_pause();
    wait_drained();
    test_random(20);
    wait_drained();
  endtask

  // reply checker
  always @(posedge clk) begin
    reply_t x;
    if (!rst && strobe) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected beat status=%0b count=%0d found=%0b index=%0d",
                 $time, status, match_count, found, found_index);
        errors++;
      end else begin
        x = pending_replies.pop_front();
        if (status !== x.status) begin
          $display("%0t: status exp %0b got %0b", $time, x.status, status);
          errors++;
        end
        if (match_count !== x.count) begin
          $display("%0t: match_count exp %0d got %0d", $time, x.count, match_count);
          errors++;
        end
        if (found !== x.found) begin
          $display("%0t: found exp %0b got %0b", $time, x.found, found);
          errors++;
        end
        if (found_index !== x.index) begin
          $display("%0t: found_index exp %0d got %0d", $time, x.index, found_index);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    gaps_on = 1'b1;
    entries_used = 0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      slots_used[e] = 0;
      written_prefix[e] = 0;
      for (int s = 0; s < NUM_SLOTS; s++) slot_written[e][s] = 1'b0;
    end
    foreach (words[i]) words[i] = make_text();
    foreach (langs[i]) langs[i] = make_text();
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_QUERY;
    entry_index = '0;
    slot_index = '0;
    amount = '0;
    nth_match = '0;
    {lang_chunk_2, lang_chunk_1, lang_chunk_0} = '0;
    {word_chunk_2, word_chunk_1, word_chunk_0} = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(420);
    test_drain_pause();
    gaps_on = 1'b0;
    test_random(120);

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
